[rtl/text_console_cursor_engine_defines.svh]
// Assertion macros used by the checker file of the cursor engine.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Clocked check, switched off while reset is held.
`define TCCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked check that also runs through reset.
`define TCCE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/tcce_pkg.sv]
// Shared types and constants of the text console cursor engine.
package tcce_pkg;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_ESC = 8'h1B;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_W = 56;

    typedef enum logic [2:0] {
        KIND_SERIAL  = 3'd0,
        KIND_CELL    = 3'd1,
        KIND_CURSOR  = 3'd2,
        KIND_TSCROLL = 3'd3,
        KIND_GLYPH   = 3'd4,
        KIND_GSCROLL = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        CFG_SERIAL_ENABLE  = 3'd0,
        CFG_TEXT_ENABLE    = 3'd1,
        CFG_GLYPH_ENABLE   = 3'd2,
        CFG_TEXT_ATTRIBUTE = 3'd3,
        CFG_GRID_COLUMNS   = 3'd4,
        CFG_GRID_ROWS      = 3'd5
    } t_cfg_idx;

    // Command slots of one job, in emission order
    localparam int CMD_SER_CR   = 0;
    localparam int CMD_SER_CHAR = 1;
    localparam int CMD_CELL     = 2;
    localparam int CMD_TSCROLL  = 3;
    localparam int CMD_CURSOR   = 4;
    localparam int CMD_GLYPH    = 5;
    localparam int CMD_GSCROLL  = 6;
    localparam int CMD_COUNT    = 7;

    typedef struct packed {
        logic [CMD_COUNT-1:0] mask;
        logic [7:0]           code;
        logic [7:0]           attr;
        logic [7:0]           cell_col;
        logic [6:0]           cell_row;
        logic [7:0]           cur_col;
        logic [6:0]           cur_row;
        logic [10:0]          pixel_x;
        logic [10:0]          pixel_y;
    } t_job;

    // Kind travels on tuser; the fields above it go to tdata from byte_out up
    typedef struct packed {
        logic [7:0]  attribute;
        logic [10:0] pixel_y;
        logic [10:0] pixel_x;
        logic [6:0]  cell_row;
        logic [7:0]  cell_column;
        logic [7:0]  byte_out;
        t_kind       kind;
    } t_cmd;

endpackage

[rtl/tcce_fifo.sv]
// Short job queue between the classifying front and the command back end.
module tcce_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcce_pkg::t_job i_wjob,
    output logic          o_full,
    input  logic          i_pop,
    output tcce_pkg::t_job o_rjob,
    output logic          o_empty
);
    import tcce_pkg::*;

    t_job               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_cnt;
    logic [QPTR_W-1:0]  n_wptr;
    logic [QPTR_W-1:0]  n_rptr;
    logic [QCNT_W-1:0]  n_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_rjob  = r_mem[r_rptr];

    always_comb begin
        n_wptr = w_push ? r_wptr + QPTR_W'(1) : r_wptr;
        n_rptr = w_pop ? r_rptr + QPTR_W'(1) : r_rptr;
        n_cnt  = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_wjob;
        end
    end

endmodule

[rtl/tcce_front.sv]
// Front end: configuration registers, cursor state and job building per character.
module tcce_front #(
    parameter int TEXT_COLUMNS = 80,
    parameter int TEXT_ROWS    = 25,
    parameter int TAB_WIDTH    = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [7:0]     i_cfg_wdata,
    input  logic           i_valid,
    input  logic [7:0]     i_code,
    output logic           o_ready,
    input  logic           i_full,
    output logic           o_push,
    output tcce_pkg::t_job o_job
);
    import tcce_pkg::*;

    localparam int TCW = $clog2(TEXT_COLUMNS);
    localparam int TNW = $clog2(TEXT_COLUMNS + TAB_WIDTH + 1);
    localparam int TRW = $clog2(TEXT_ROWS);
    localparam int PW  = $clog2(TAB_WIDTH);

    // Configuration
    logic       r_ser_en;
    logic       r_text_en;
    logic       r_glyph_en;
    logic [7:0] r_attr;
    logic [7:0] r_gcols;
    logic [6:0] r_grows;

    // Cursor state; the phase registers track column modulo the tab width
    logic [TCW-1:0] r_tcol, n_tcol;
    logic [TRW-1:0] r_trow, n_trow;
    logic [PW-1:0]  r_tph,  n_tph;
    logic [7:0]     r_gcol, n_gcol;
    logic [6:0]     r_grow, n_grow;
    logic [PW-1:0]  r_gph,  n_gph;

    logic           w_accept;
    logic           w_is_nl, w_is_cr, w_is_tab, w_is_esc;
    logic           w_glyph_act;
    logic [TRW:0]   w_trow_inc;
    logic           w_tnl_scroll;
    logic [TNW-1:0] w_ttab_n, w_tinc_n;
    logic           w_tnl;
    logic [8:0]     w_gtab_n, w_ginc_n;
    logic [7:0]     w_grow_inc;
    logic           w_gnl;
    logic [PW-1:0]  w_tph_inc, w_gph_inc;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;

    assign w_is_nl  = (i_code == CH_NL);
    assign w_is_cr  = (i_code == CH_CR);
    assign w_is_tab = (i_code == CH_TAB);
    assign w_is_esc = (i_code == CH_ESC);

    assign w_glyph_act = r_glyph_en && (r_gcols != 8'd0) && (r_grows != 7'd0);

    assign w_trow_inc   = {1'b0, r_trow} + (TRW+1)'(1);
    assign w_tnl_scroll = (w_trow_inc >= (TRW+1)'(TEXT_ROWS));
    assign w_ttab_n     = TNW'(r_tcol) + TNW'(TAB_WIDTH) - TNW'(r_tph);
    assign w_tinc_n     = TNW'(r_tcol) + TNW'(1);
    assign w_tph_inc    = (r_tph == PW'(TAB_WIDTH - 1)) ? '0 : r_tph + PW'(1);

    assign w_gtab_n   = {1'b0, r_gcol} + 9'(TAB_WIDTH) - 9'(r_gph);
    assign w_ginc_n   = {1'b0, r_gcol} + 9'd1;
    assign w_grow_inc = {1'b0, r_grow} + 8'd1;
    assign w_gph_inc  = (r_gph == PW'(TAB_WIDTH - 1)) ? '0 : r_gph + PW'(1);

    always_comb begin
        n_tcol = r_tcol;
        n_trow = r_trow;
        n_tph  = r_tph;
        n_gcol = r_gcol;
        n_grow = r_grow;
        n_gph  = r_gph;
        w_tnl  = 1'b0;
        w_gnl  = 1'b0;

        o_job          = '0;
        o_job.code     = i_code;
        o_job.attr     = r_attr;
        o_job.cell_col = 8'(r_tcol);
        o_job.cell_row = 7'(r_trow);
        o_job.pixel_x  = {r_gcol, 3'b000};
        o_job.pixel_y  = {r_grow, 4'b0000};

        if (r_ser_en) begin
            o_job.mask[CMD_SER_CR]   = w_is_nl;
            o_job.mask[CMD_SER_CHAR] = 1'b1;
        end

        if (r_text_en) begin
            if (w_is_nl) begin
                w_tnl = 1'b1;
            end else if (w_is_cr) begin
                n_tcol = '0;
                n_tph  = '0;
            end else if (w_is_tab) begin
                if (w_ttab_n >= TNW'(TEXT_COLUMNS)) begin
                    w_tnl = 1'b1;
                end else begin
                    n_tcol = w_ttab_n[TCW-1:0];
                    n_tph  = '0;
                end
            end else begin
                o_job.mask[CMD_CELL] = 1'b1;
                if (w_tinc_n >= TNW'(TEXT_COLUMNS)) begin
                    w_tnl = 1'b1;
                end else begin
                    n_tcol = w_tinc_n[TCW-1:0];
                    n_tph  = w_tph_inc;
                end
            end
            if (w_tnl) begin
                n_tcol = '0;
                n_tph  = '0;
                n_trow = w_tnl_scroll ? TRW'(TEXT_ROWS - 1) : w_trow_inc[TRW-1:0];
                o_job.mask[CMD_TSCROLL] = w_tnl_scroll;
            end
            // Every text character ends with the new cursor position
            o_job.mask[CMD_CURSOR] = 1'b1;
            o_job.cur_col          = 8'(n_tcol);
            o_job.cur_row          = 7'(n_trow);
        end

        if (w_glyph_act) begin
            if (w_is_nl) begin
                w_gnl = 1'b1;
            end else if (w_is_cr) begin
                n_gcol = '0;
                n_gph  = '0;
            end else if (w_is_tab) begin
                if (w_gtab_n >= {1'b0, r_gcols}) begin
                    w_gnl = 1'b1;
                end else begin
                    n_gcol = w_gtab_n[7:0];
                    n_gph  = '0;
                end
            end else if (!w_is_esc) begin
                // Draw at the current, possibly stale, position
                o_job.mask[CMD_GLYPH] = 1'b1;
                if (w_ginc_n >= {1'b0, r_gcols}) begin
                    w_gnl = 1'b1;
                end else begin
                    n_gcol = w_ginc_n[7:0];
                    n_gph  = w_gph_inc;
                end
            end
            if (w_gnl) begin
                n_gcol = '0;
                n_gph  = '0;
                if (w_grow_inc >= {1'b0, r_grows}) begin
                    o_job.mask[CMD_GSCROLL] = (r_grows > 7'd1);
                    n_grow = r_grows - 7'd1;
                end else begin
                    n_grow = w_grow_inc[6:0];
                end
            end
        end

        o_push = w_accept && (o_job.mask != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_en   <= 1'b1;
            r_text_en  <= 1'b0;
            r_glyph_en <= 1'b0;
            r_attr     <= 8'h07;
            r_gcols    <= 8'd80;
            r_grows    <= 7'd25;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SERIAL_ENABLE:  r_ser_en   <= i_cfg_wdata[0];
                CFG_TEXT_ENABLE:    r_text_en  <= i_cfg_wdata[0];
                CFG_GLYPH_ENABLE:   r_glyph_en <= i_cfg_wdata[0];
                CFG_TEXT_ATTRIBUTE: r_attr     <= i_cfg_wdata;
                CFG_GRID_COLUMNS:   r_gcols    <= i_cfg_wdata;
                CFG_GRID_ROWS:      r_grows    <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcol <= '0;
            r_trow <= '0;
            r_tph  <= '0;
            r_gcol <= '0;
            r_grow <= '0;
            r_gph  <= '0;
        end else if (w_accept) begin
            r_tcol <= n_tcol;
            r_trow <= n_trow;
            r_tph  <= n_tph;
            r_gcol <= n_gcol;
            r_grow <= n_grow;
            r_gph  <= n_gph;
        end
    end

endmodule

[rtl/tcce_back.sv]
// Back end: walks the pending commands of one job and drives the output register.
module tcce_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tcce_pkg::t_job          i_job,
    input  logic                    i_empty,
    output logic                    o_pop,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [tcce_pkg::OUT_W-1:0] o_m_tdata,
    output logic [2:0]              o_m_tuser,
    output logic                    o_m_tlast
);
    import tcce_pkg::*;

    t_job                 r_job;
    logic [CMD_COUNT-1:0] r_pend, n_pend;
    logic                 r_ovld;
    t_cmd                 r_out;
    logic                 r_olast;

    logic                 w_can_out;
    logic                 w_emit;
    logic [CMD_COUNT-1:0] w_sel;
    logic [CMD_COUNT-1:0] w_rest;
    t_cmd                 w_cmd;

    assign w_can_out = !r_ovld || i_m_tready;
    assign w_emit    = (r_pend != '0) && w_can_out;
    // Lowest pending slot goes first
    assign w_sel     = r_pend & (~r_pend + CMD_COUNT'(1));
    assign w_rest    = r_pend & ~w_sel;

    always_comb begin
        w_cmd = '0;
        if (w_sel[CMD_SER_CR]) begin
            w_cmd.kind     = KIND_SERIAL;
            w_cmd.byte_out = CH_CR;
        end else if (w_sel[CMD_SER_CHAR]) begin
            w_cmd.kind     = KIND_SERIAL;
            w_cmd.byte_out = r_job.code;
        end else if (w_sel[CMD_CELL]) begin
            w_cmd.kind        = KIND_CELL;
            w_cmd.byte_out    = r_job.code;
            w_cmd.cell_column = r_job.cell_col;
            w_cmd.cell_row    = r_job.cell_row;
            w_cmd.attribute   = r_job.attr;
        end else if (w_sel[CMD_TSCROLL]) begin
            w_cmd.kind      = KIND_TSCROLL;
            w_cmd.attribute = r_job.attr;
        end else if (w_sel[CMD_CURSOR]) begin
            w_cmd.kind        = KIND_CURSOR;
            w_cmd.cell_column = r_job.cur_col;
            w_cmd.cell_row    = r_job.cur_row;
        end else if (w_sel[CMD_GLYPH]) begin
            w_cmd.kind     = KIND_GLYPH;
            w_cmd.byte_out = r_job.code;
            w_cmd.pixel_x  = r_job.pixel_x;
            w_cmd.pixel_y  = r_job.pixel_y;
        end else begin
            w_cmd.kind = KIND_GSCROLL;
        end
    end

    always_comb begin
        n_pend = w_emit ? w_rest : r_pend;
        // Load the next job as the current one finishes
        o_pop  = !i_empty && (n_pend == '0);
        if (o_pop) begin
            n_pend = i_job.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (w_emit) begin
                r_ovld <= 1'b1;
            end else if (i_m_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (w_emit) begin
            r_out   <= w_cmd;
            r_olast <= (w_rest == '0);
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {3'b000, r_out.attribute, r_out.pixel_y, r_out.pixel_x,
                         r_out.cell_row, r_out.cell_column, r_out.byte_out};
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_olast;

endmodule

[rtl/text_console_cursor_engine.sv]
// The first command of a character passes through the job queue and the back end's job
// register before the output register. The back end sends one command per cycle while the
// receiver is ready; a character causes 1 to 6 commands, and a four-deep job queue lets
// input run ahead of output. Characters that cause no command never reach the queue.
// Reset (synchronous, active low) empties the queue, zeroes both cursors and
// loads the register defaults: serial on, text and glyph off, attribute 7, grid 80x25.
module text_console_cursor_engine #(
    parameter int TEXT_COLUMNS = 80,
    parameter int TEXT_ROWS    = 25,
    parameter int TAB_WIDTH    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] code
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] byte_out, [15:8] cell_column, [22:16] cell_row, [33:23] pixel_x,
    // [44:34] pixel_y, [52:45] attribute, [55:53] zero
    output logic [tcce_pkg::OUT_W-1:0] o_m_tdata,
    output logic [2:0]  o_m_tuser,   // [2:0] kind
    output logic        o_m_tlast,   // last
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata
);
    import tcce_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_job w_wjob;
    t_job w_rjob;

    tcce_front #(
        .TEXT_COLUMNS (TEXT_COLUMNS),
        .TEXT_ROWS    (TEXT_ROWS),
        .TAB_WIDTH    (TAB_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_tvalid),
        .i_code      (i_s_tdata),
        .o_ready     (o_s_tready),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_wjob)
    );

    tcce_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wjob  (w_wjob),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rjob  (w_rjob),
        .o_empty (w_empty)
    );

    tcce_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_rjob),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

[rtl/tcce_checker.sv]
// Port-level checks for the cursor engine and their binding to the top level.
`include "text_console_cursor_engine_defines.svh"

module tcce_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    input  logic [tcce_pkg::OUT_W-1:0] o_m_tdata,
    input  logic [2:0]                 o_m_tuser,
    input  logic                       o_m_tlast
);
    import tcce_pkg::*;

    logic             w_stall;
    logic             w_serial;
    logic [OUT_W+3:0] w_beat;

    assign w_stall  = o_m_tvalid && !i_m_tready;
    assign w_serial = o_m_tvalid && (o_m_tuser == KIND_SERIAL);
    assign w_beat   = {o_m_tlast, o_m_tuser, o_m_tdata};

    // A stalled command holds its payload
    `TCCE_ASSERT(a_out_hold, w_stall |=> o_m_tvalid && $stable(w_beat), "output changed while stalled")

    // Only defined command kinds leave the block
    `TCCE_ASSERT(a_kind_range, o_m_tvalid |-> o_m_tuser <= KIND_GSCROLL, "undefined command kind")

    // Serial bytes carry no position or attribute
    `TCCE_ASSERT(a_serial_clean, w_serial |-> o_m_tdata[OUT_W-1:8] == '0, "serial with stray fields")

    // Reset drops any pending output
    `TCCE_ASSERT_RST(a_reset_idle, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (.*);

[test/text_console_cursor_engine_checker.sv]
// Command predictor and scoreboard for the text console cursor engine.
`timescale 1ns / 1ps

module text_console_cursor_engine_checker #(
    parameter int TEXT_COLUMNS = 80,
    parameter int TEXT_ROWS    = 25,
    parameter int TAB_WIDTH    = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    input  logic [7:0]                 i_s_tdata,
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    input  logic [tcce_pkg::OUT_W-1:0] i_m_tdata,
    input  logic [2:0]                 i_m_tuser,
    input  logic                       i_m_tlast,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [7:0]                 i_cfg_wdata,
    output int                         o_failures,
    output int                         o_pending,
    output int                         o_chars,
    output int                         o_commands,
    output int                         o_text_scrolls,
    output int                         o_glyph_scrolls
);
    import tcce_pkg::*;

    localparam int MAX_CMDS_PER_CHAR = 6;

    typedef struct packed {
        logic last;
        t_cmd cmd;
    } console_cmd_t;

    // register copies
    logic       serial_on;
    logic       text_on;
    logic       glyph_on;
    logic [7:0] cell_attr;
    logic [7:0] grid_cols;
    logic [6:0] grid_rows;

    // cursor copies
    int unsigned txt_col;
    int unsigned txt_row;
    int unsigned gl_col;
    int unsigned gl_row;

    console_cmd_t char_cmds[$];
    console_cmd_t pending_cmds[$];

    task automatic add_command(input t_kind kind, input int unsigned byte_v,
                               input int unsigned col, input int unsigned row,
                               input int unsigned px, input int unsigned py,
                               input int unsigned attr);
        console_cmd_t c;
        if (char_cmds.size() >= MAX_CMDS_PER_CHAR) begin
            return;
        end
        c.last             = 1'b0;
        c.cmd.kind         = kind;
        c.cmd.byte_out     = 8'(byte_v);
        c.cmd.cell_column  = 8'(col);
        c.cmd.cell_row     = 7'(row);
        c.cmd.pixel_x      = 11'(px);
        c.cmd.pixel_y      = 11'(py);
        c.cmd.attribute    = 8'(attr);
        char_cmds.push_back(c);
    endtask

    task automatic txt_line_break();
        txt_col = 0;
        txt_row++;
        if (txt_row >= TEXT_ROWS) begin
            add_command(KIND_TSCROLL, 0, 0, 0, 0, 0, cell_attr);
            txt_row = TEXT_ROWS - 1;
        end
        txt_row &= 'h1F;
        add_command(KIND_CURSOR, 0, txt_col, txt_row, 0, 0, 0);
    endtask

    task automatic text_advance(input int unsigned ncol);
        if (ncol >= TEXT_COLUMNS) begin
            txt_line_break();
        end else begin
            txt_col = ncol & 'h7F;
            add_command(KIND_CURSOR, 0, txt_col, txt_row, 0, 0, 0);
        end
    endtask

    task automatic text_char(input logic [7:0] code);
        case (code)
            CH_NL: begin
                txt_line_break();
            end
            CH_CR: begin
                txt_col = 0;
                add_command(KIND_CURSOR, 0, 0, txt_row, 0, 0, 0);
            end
            CH_TAB: begin
                text_advance(txt_col + TAB_WIDTH - txt_col % TAB_WIDTH);
            end
            default: begin
                // escape lands here too: the text screen shows it as a cell
                add_command(KIND_CELL, code, txt_col, txt_row, 0, 0, cell_attr);
                text_advance(txt_col + 1);
            end
        endcase
    endtask

    task automatic glyph_newline();
        gl_col = 0;
        gl_row++;
        if (gl_row >= grid_rows) begin
            // a single-row grid has nothing to scroll
            if (grid_rows > 1) begin
                add_command(KIND_GSCROLL, 0, 0, 0, 0, 0, 0);
            end
            gl_row = grid_rows - 1;
        end
        gl_row &= 'h7F;
    endtask

    task automatic glyph_advance(input int unsigned ncol);
        if (ncol >= grid_cols) begin
            glyph_newline();
        end else begin
            gl_col = ncol & 'hFF;
        end
    endtask

    task automatic glyph_char(input logic [7:0] code);
        case (code)
            CH_NL: begin
                glyph_newline();
            end
            CH_CR: begin
                gl_col = 0;
            end
            CH_TAB: begin
                glyph_advance(gl_col + TAB_WIDTH - gl_col % TAB_WIDTH);
            end
            CH_ESC: begin
            end
            default: begin
                // a shrunken grid still draws at the stale cursor first
                add_command(KIND_GLYPH, code, 0, 0, gl_col * 8, gl_row * 16, 0);
                glyph_advance(gl_col + 1);
            end
        endcase
    endtask

    task automatic predict_console_commands(input logic [7:0] code);
        console_cmd_t c;
        char_cmds.delete();
        if (serial_on) begin
            if (code == CH_NL) begin
                add_command(KIND_SERIAL, CH_CR, 0, 0, 0, 0, 0);
            end
            add_command(KIND_SERIAL, code, 0, 0, 0, 0, 0);
        end
        if (text_on) begin
            text_char(code);
        end
        if (glyph_on && grid_cols != 0 && grid_rows != 0) begin
            glyph_char(code);
        end
        for (int k = 0; k < char_cmds.size(); k++) begin
            c      = char_cmds[k];
            c.last = (k == char_cmds.size() - 1);
            pending_cmds.push_back(c);
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        o_failures++;
        $display("%0t: command %0d: %s got 0x%0h, expected 0x%0h",
                 $realtime, o_commands, what, got, want);
    endtask

    task automatic check_command(input logic [OUT_W-1:0] data, input logic [2:0] user,
                                 input logic last);
        console_cmd_t got;
        console_cmd_t want;
        // tdata carries the fields above kind, kind comes from tuser
        got.cmd  = {data[OUT_W-4:0], user};
        got.last = last;
        if (got.cmd.kind == KIND_TSCROLL) begin
            o_text_scrolls++;
        end
        if (got.cmd.kind == KIND_GSCROLL) begin
            o_glyph_scrolls++;
        end
        if (pending_cmds.size() == 0) begin
            report_mismatch("unexpected command, kind", got.cmd.kind, 0);
        end else begin
            want = pending_cmds.pop_front();
            if (got.cmd.kind !== want.cmd.kind)
                report_mismatch("kind", got.cmd.kind, want.cmd.kind);
            if (got.cmd.byte_out !== want.cmd.byte_out)
                report_mismatch("byte_out", got.cmd.byte_out, want.cmd.byte_out);
            if (got.cmd.cell_column !== want.cmd.cell_column)
                report_mismatch("cell_column", got.cmd.cell_column, want.cmd.cell_column);
            if (got.cmd.cell_row !== want.cmd.cell_row)
                report_mismatch("cell_row", got.cmd.cell_row, want.cmd.cell_row);
            if (got.cmd.pixel_x !== want.cmd.pixel_x)
                report_mismatch("pixel_x", got.cmd.pixel_x, want.cmd.pixel_x);
            if (got.cmd.pixel_y !== want.cmd.pixel_y)
                report_mismatch("pixel_y", got.cmd.pixel_y, want.cmd.pixel_y);
            if (got.cmd.attribute !== want.cmd.attribute)
                report_mismatch("attribute", got.cmd.attribute, want.cmd.attribute);
            if (got.last !== want.last)
                report_mismatch("last", got.last, want.last);
        end
        o_commands++;
    endtask

    initial begin
        o_failures      = 0;
        o_pending       = 0;
        o_chars         = 0;
        o_commands      = 0;
        o_text_scrolls  = 0;
        o_glyph_scrolls = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            serial_on = 1'b1;
            text_on   = 1'b0;
            glyph_on  = 1'b0;
            cell_attr = 8'd7;
            grid_cols = 8'd80;
            grid_rows = 7'd25;
            txt_col   = 0;
            txt_row   = 0;
            gl_col    = 0;
            gl_row    = 0;
            pending_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SERIAL_ENABLE:  serial_on = i_cfg_wdata[0];
                    CFG_TEXT_ENABLE:    text_on   = i_cfg_wdata[0];
                    CFG_GLYPH_ENABLE:   glyph_on  = i_cfg_wdata[0];
                    CFG_TEXT_ATTRIBUTE: cell_attr = i_cfg_wdata;
                    CFG_GRID_COLUMNS:   grid_cols = i_cfg_wdata;
                    CFG_GRID_ROWS:      grid_rows = i_cfg_wdata[6:0];
                    default: begin
                    end
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_console_commands(i_s_tdata);
                o_chars++;
            end
            if (i_m_tvalid && i_m_tready) begin
                check_command(i_m_tdata, i_m_tuser, i_m_tlast);
            end
        end
        o_pending = pending_cmds.size();
    end

endmodule

[test/text_console_cursor_engine_tb.sv]
// Stimulus, clocking and verdict for the text console cursor engine.
`timescale 1ns / 1ps

module text_console_cursor_engine_tb;
    import tcce_pkg::*;

    // indexes past the register list, written to show they are ignored
    localparam logic [2:0] CFG_SPARE_LOW  = 3'd6;
    localparam logic [2:0] CFG_SPARE_HIGH = 3'd7;

    localparam int RUN_LIMIT      = 400000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_CHARS    = 45;

    typedef struct {
        logic       serial;
        logic       text;
        logic       glyph;
        logic [7:0] attr;
        logic [7:0] cols;
        logic [6:0] rows;
    } console_setup_t;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             s_tvalid    = 1'b0;
    logic [7:0]       s_tdata     = 8'h00;
    logic             m_tready    = 1'b0;
    logic             cfg_we      = 1'b0;
    logic [2:0]       cfg_idx     = 3'd0;
    logic [7:0]       cfg_wdata   = 8'h00;
    logic             s_tready;
    logic             m_tvalid;
    logic [OUT_W-1:0] m_tdata;
    logic [2:0]       m_tuser;
    logic             m_tlast;

    int failures;
    int pending;
    int chars_seen;
    int cmds_seen;
    int text_scrolls;
    int glyph_scrolls;
    int cycles       = 0;
    int burst_left   = 0;
    int settings_run = 0;

    text_console_cursor_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    text_console_cursor_engine_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .i_m_tlast       (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .o_failures      (failures),
        .o_pending       (pending),
        .o_chars         (chars_seen),
        .o_commands      (cmds_seen),
        .o_text_scrolls  (text_scrolls),
        .o_glyph_scrolls (glyph_scrolls)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("timed out after %0d cycles, %0d commands outstanding",
                     cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: stretches of always ready, random stalls, or a rotating pattern
    initial begin : receiver
        int         mode;
        int         stretch;
        logic [7:0] pattern;
        forever begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(10, 60);
            pattern = 8'($urandom) | 8'h01;
            repeat (stretch) begin
                @(negedge i_clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: begin
                        m_tready <= pattern[0];
                        pattern = {pattern[0], pattern[7:1]};
                    end
                endcase
            end
        end
    end

    // call at a falling edge; returns at the falling edge after the transfer
    task automatic send_code(input logic [7:0] code);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
            gap        = $urandom_range(0, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        burst_left--;
    endtask

    // drop valid and wait for every expected command, then let the block go quiet
    task automatic settle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge i_clk);
    endtask

    task automatic apply_setup(input console_setup_t s);
        write_reg(CFG_SPARE_LOW, 8'($urandom));
        write_reg(CFG_SERIAL_ENABLE, {7'd0, s.serial});
        write_reg(CFG_TEXT_ENABLE, {7'd0, s.text});
        write_reg(CFG_GLYPH_ENABLE, {7'd0, s.glyph});
        write_reg(CFG_TEXT_ATTRIBUTE, s.attr);
        write_reg(CFG_GRID_COLUMNS, s.cols);
        write_reg(CFG_GRID_ROWS, {1'b0, s.rows});
        write_reg(CFG_SPARE_HIGH, 8'($urandom));
        cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_run++;
    endtask

    function automatic console_setup_t make_setup(input logic serial, input logic text,
                                                  input logic glyph, input logic [7:0] attr,
                                                  input logic [7:0] cols,
                                                  input logic [6:0] rows);
        console_setup_t s;
        s.serial = serial;
        s.text   = text;
        s.glyph  = glyph;
        s.attr   = attr;
        s.cols   = cols;
        s.rows   = rows;
        return s;
    endfunction

    function automatic console_setup_t random_setup();
        console_setup_t s;
        s.serial = 1'($urandom);
        s.text   = 1'($urandom);
        s.glyph  = 1'($urandom);
        // keep most phases busy on at least one target
        if (!s.serial && !s.text && !s.glyph && $urandom_range(0, 3) != 0) begin
            s.text = 1'b1;
        end
        case ($urandom_range(0, 3))
            0:       s.attr = 8'h00;
            1:       s.attr = 8'hFF;
            default: s.attr = 8'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       s.cols = 8'd0;
            1:       s.cols = 8'd1;
            2:       s.cols = 8'd2;
            3:       s.cols = 8'd255;
            4:       s.cols = 8'd8;
            default: s.cols = 8'($urandom_range(1, 255));
        endcase
        case ($urandom_range(0, 6))
            0:       s.rows = 7'd0;
            1:       s.rows = 7'd1;
            2:       s.rows = 7'd2;
            3:       s.rows = 7'd127;
            default: s.rows = 7'($urandom_range(1, 127));
        endcase
        return s;
    endfunction

    function automatic logic [7:0] random_code(input int nl_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < nl_pct)      return CH_NL;
        if (r < nl_pct + 4)  return CH_CR;
        if (r < nl_pct + 14) return CH_TAB;
        if (r < nl_pct + 18) return CH_ESC;
        if (r < nl_pct + 60) return 8'($urandom_range(32, 126));
        return 8'($urandom);
    endfunction

    initial begin : stimulus
        int nl_pct;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: serial only, newline goes out as CR then LF
        send_code(CH_NL);
        send_code(8'h00);
        send_code(8'hFF);
        send_code(CH_ESC);
        settle();

        // tiny grid: glyph wrap and scroll within a few characters
        apply_setup(make_setup(1'b1, 1'b1, 1'b1, 8'hFF, 8'd3, 7'd2));
        send_code(8'h41);
        send_code(8'h42);
        send_code(8'h43);
        send_code(8'h44);
        send_code(8'h45);
        send_code(8'h46);
        send_code(CH_TAB);
        send_code(CH_ESC);
        send_code(CH_CR);
        send_code(CH_NL);
        send_code(8'h80);
        settle();

        // single-row grid: newline without a glyph scroll
        apply_setup(make_setup(1'b0, 1'b1, 1'b1, 8'h00, 8'd255, 7'd1));
        send_code(CH_NL);
        send_code(CH_TAB);
        send_code(8'h78);
        settle();

        // zero columns, then zero rows: glyph path off
        apply_setup(make_setup(1'b1, 1'b1, 1'b1, 8'h5A, 8'd0, 7'd25));
        send_code(8'h79);
        settle();
        apply_setup(make_setup(1'b0, 1'b1, 1'b1, 8'hA5, 8'd5, 7'd0));
        send_code(CH_NL);
        settle();

        // every target off: a character with no commands
        apply_setup(make_setup(1'b0, 1'b0, 1'b0, 8'h07, 8'd80, 7'd25));
        send_code(8'h71);
        settle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                // long lines on the widest grid to reach the text wrap
                apply_setup(make_setup(1'b0, 1'b1, 1'b1, 8'($urandom), 8'd255, 7'd127));
                nl_pct = 0;
            end else if (phase == 1) begin
                // shrink below the glyph cursor left by the previous phase
                apply_setup(make_setup(1'b1, 1'b1, 1'b1, 8'($urandom), 8'd2, 7'd2));
                nl_pct = 8;
            end else begin
                apply_setup(random_setup());
                case ($urandom_range(0, 2))
                    0:       nl_pct = 2;
                    1:       nl_pct = 8;
                    default: nl_pct = 20;
                endcase
            end
            repeat (PHASE_CHARS) send_code(random_code(nl_pct));
            settle();
        end

        $display("%0d characters, %0d commands checked over %0d register settings",
                 chars_seen, cmds_seen, settings_run + 1);
        $display("scrolls seen: %0d text, %0d glyph", text_scrolls, glyph_scrolls);
        if (failures == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
